>>> rtl/anagram_window_search_assert.svh
// Assertion macros for the anagram window search checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef ANAGRAM_WINDOW_SEARCH_ASSERT_SVH
`define ANAGRAM_WINDOW_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AWS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("aws checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define AWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("aws checker: next-cycle property failed");

`endif

>>> rtl/aws_pkg.sv
// Package for the anagram window search block: sizes, item codes and
// the control struct of the balance bank. Depends on nothing.
package aws_pkg;

  // Default sizes of the search.
  localparam int AWS_MAX_PATTERN = 64;
  localparam int AWS_ALPHABET    = 26;

  // Fixed field widths of the transactions.
  localparam int KIND_W   = 2;
  localparam int SYMBOL_W = 5;
  localparam int ERR_W    = 2;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2
  } kind_e;

  // Error codes of a result.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 2'd0,
    ERR_TOO_LONG     = 2'd1,
    ERR_LATE_PATTERN = 2'd2
  } err_e;

  // Update command for the balance bank.
  typedef struct packed {
    logic clear;
    logic inc_en;
    logic dec_en;
  } aws_bal_ctl_t;

endpackage

>>> rtl/aws_if.sv
// Valid/ready channel interfaces for the anagram window search block.
// Depends on aws_pkg for the field widths.
interface aws_in_if import aws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SYMBOL_W-1:0] symbol;

  modport source (output valid, output kind, output symbol, input ready);
  modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface aws_out_if import aws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             match_now;
  logic             found;
  logic [ERR_W-1:0] error;

  modport source (output valid, output match_now, output found, output error, input ready);
  modport sink   (input valid, input match_now, input found, input error, output ready);
endinterface

>>> rtl/aws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module aws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; a read of the address written
  // in the same cycle returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/aws_balance_bank.sv
// Per-symbol count balances (pattern minus window) and the count of
// symbols out of balance. Depends on aws_pkg.
module aws_balance_bank import aws_pkg::*; #(
  parameter int ALPHABET    = AWS_ALPHABET,
  parameter int MAX_PATTERN = AWS_MAX_PATTERN,
  localparam int SLOT_W = $clog2(ALPHABET + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aws_bal_ctl_t      ctl_i,
  input  logic [SLOT_W-1:0] inc_slot_i,
  input  logic [SLOT_W-1:0] dec_slot_i,
  output logic              balanced_next_o
);

  // One lane per letter plus one shared lane for foreign codes.
  localparam int LANES = ALPHABET + 1;
  localparam int BAL_W = $clog2(MAX_PATTERN + 1) + 1;
  localparam int CNT_W = $clog2(ALPHABET + 2);

  logic signed [BAL_W-1:0] bal_q [LANES];
  logic [LANES-1:0]        inc_only;
  logic [LANES-1:0]        dec_only;
  logic [LANES-1:0]        is_zero;
  logic [LANES-1:0]        is_plus_one;
  logic [LANES-1:0]        is_minus_one;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        cnt_d;
  logic                    up_inc;
  logic                    up_dec;
  logic                    down_inc;
  logic                    down_dec;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic                    inc_hit;
    logic                    dec_hit;
    logic signed [BAL_W-1:0] bal_d;

    // A lane hit by both an increment and a decrement stays unchanged.
    assign inc_hit         = ctl_i.inc_en && (inc_slot_i == SLOT_W'(i));
    assign dec_hit         = ctl_i.dec_en && (dec_slot_i == SLOT_W'(i));
    assign inc_only[i]     = inc_hit && !dec_hit;
    assign dec_only[i]     = dec_hit && !inc_hit;
    assign is_zero[i]      = (bal_q[i] == '0);
    assign is_plus_one[i]  = (bal_q[i] == BAL_W'(1));
    assign is_minus_one[i] = (bal_q[i] == '1);

    always_comb begin
      bal_d = bal_q[i];
      if (ctl_i.clear) begin
        bal_d = '0;
      end else if (inc_only[i]) begin
        bal_d = bal_q[i] + BAL_W'(1);
      end else if (dec_only[i]) begin
        bal_d = bal_q[i] - BAL_W'(1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bal_q[i] <= '0;
      end else begin
        bal_q[i] <= bal_d;
      end
    end
  end

  // At most one lane takes each kind of transition, so the reductions
  // pick out the single affected lane.
  assign up_inc   = |(inc_only & is_zero);
  assign up_dec   = |(dec_only & is_zero);
  assign down_inc = |(inc_only & is_minus_one);
  assign down_dec = |(dec_only & is_plus_one);

  always_comb begin
    if (ctl_i.clear) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + CNT_W'(up_inc) + CNT_W'(up_dec)
            - CNT_W'(down_inc) - CNT_W'(down_dec);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign balanced_next_o = (cnt_d == '0);

endmodule

>>> rtl/anagram_window_search.sv
// Top level of the anagram window search block.
// Depends on aws_pkg, aws_if, aws_ram and aws_balance_bank.
//
// Takes clear, pattern-symbol and text-symbol transactions, one per clock,
// and returns one result transaction for each, the cycle after acceptance,
// from an output register; the input stalls only while that register holds
// a result that has not been taken. After every text symbol the result says
// whether the last pattern-length text symbols are a permutation of the
// pattern, with a sticky found flag since the last clear. Symbol balances
// live in one flip-flop lane per letter. The text window is a RAM of
// MAX_PATTERN entries with one write and one registered read port; the
// entry that leaves the window is read ahead at the next ring position,
// with a bypass for a pattern of length one. The ring needs no
// clearing after reset, since only written entries are ever read.
module anagram_window_search import aws_pkg::*; #(
  parameter int MAX_PATTERN = AWS_MAX_PATTERN,
  parameter int ALPHABET    = AWS_ALPHABET
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aws_in_if.sink     item_i,
  aws_out_if.source  result_o
);

  localparam int SLOT_W = $clog2(ALPHABET + 1);
  localparam int PLW    = $clog2(MAX_PATTERN + 1);
  localparam int RW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CMP_W  = (SLOT_W > SYMBOL_W) ? SLOT_W : SYMBOL_W;

  logic               acc;
  logic [CMP_W-1:0]   sym_ext;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  out_slot;
  logic [SLOT_W-1:0]  ram_rdata;
  logic [SLOT_W-1:0]  inc_slot;
  logic               balanced_next;
  aws_bal_ctl_t       bal_ctl;

  logic [PLW-1:0]     pat_len_q, pat_len_d;
  logic [PLW-1:0]     text_seen_q, text_seen_d;
  logic [RW-1:0]      ring_pos_q, ring_pos_d;
  logic               started_q, started_d;
  logic               found_q, found_d;
  logic               fwd_q, fwd_d;
  logic [SLOT_W-1:0]  fwd_data_q;
  logic               ram_we;
  logic               text_live;
  logic               res_match;
  err_e               res_err;

  logic               out_valid_q;
  logic               out_match_q;
  logic               out_found_q;
  err_e               out_err_q;

  // Input is taken whenever the output register is free or being drained.
  assign item_i.ready = !out_valid_q || result_o.ready;
  assign acc          = item_i.valid && item_i.ready;

  // Codes at or above the alphabet size share one foreign lane.
  assign sym_ext = CMP_W'(item_i.symbol);
  assign slot    = (sym_ext < CMP_W'(ALPHABET)) ? SLOT_W'(sym_ext) : SLOT_W'(ALPHABET);

  // Symbol leaving the window, with a bypass of last cycle's write.
  assign out_slot = fwd_q ? fwd_data_q : ram_rdata;

  // Next-state logic for one accepted transaction.
  always_comb begin
    pat_len_d   = pat_len_q;
    text_seen_d = text_seen_q;
    ring_pos_d  = ring_pos_q;
    started_d   = started_q;
    bal_ctl     = '0;
    inc_slot    = out_slot;
    ram_we      = 1'b0;
    text_live   = 1'b0;
    res_err     = ERR_NONE;
    if (acc) begin
      unique case (item_i.kind)
        KIND_CLEAR: begin
          pat_len_d     = '0;
          text_seen_d   = '0;
          ring_pos_d    = '0;
          started_d     = 1'b0;
          bal_ctl.clear = 1'b1;
        end
        KIND_PATTERN: begin
          if (started_q) begin
            res_err = ERR_LATE_PATTERN;
          end else if (pat_len_q >= PLW'(MAX_PATTERN)) begin
            res_err = ERR_TOO_LONG;
          end else begin
            bal_ctl.inc_en = 1'b1;
            inc_slot       = slot;
            pat_len_d      = pat_len_q + PLW'(1);
          end
        end
        KIND_TEXT: begin
          started_d = 1'b1;
          if (pat_len_q != '0) begin
            text_live = 1'b1;
            if (text_seen_q >= pat_len_q) begin
              bal_ctl.inc_en = 1'b1;
            end else begin
              text_seen_d = text_seen_q + PLW'(1);
            end
            bal_ctl.dec_en = 1'b1;
            ram_we         = 1'b1;
            if ((PLW'(ring_pos_q) + PLW'(1)) >= pat_len_q) begin
              ring_pos_d = '0;
            end else begin
              ring_pos_d = ring_pos_q + RW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Window check after the balance update of this transaction.
  assign res_match = text_live && (text_seen_d == pat_len_q) && balanced_next;

  always_comb begin
    found_d = found_q;
    if (acc && (item_i.kind == KIND_CLEAR)) begin
      found_d = 1'b0;
    end else if (res_match) begin
      found_d = 1'b1;
    end
  end

  assign fwd_d = ram_we && (ring_pos_q == ring_pos_d);

  aws_balance_bank #(
    .ALPHABET    (ALPHABET),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_bank (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (bal_ctl),
    .inc_slot_i      (inc_slot),
    .dec_slot_i      (slot),
    .balanced_next_o (balanced_next)
  );

  // The read address runs one step ahead of the ring position.
  aws_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ring_pos_q),
    .wdata_i (slot),
    .raddr_i (ring_pos_d),
    .rdata_o (ram_rdata)
  );

  // Query state and bypass control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      text_seen_q <= '0;
      ring_pos_q  <= '0;
      started_q   <= 1'b0;
      found_q     <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      pat_len_q   <= pat_len_d;
      text_seen_q <= text_seen_d;
      ring_pos_q  <= ring_pos_d;
      started_q   <= started_d;
      found_q     <= found_d;
      fwd_q       <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= slot;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_match_q <= res_match;
      out_found_q <= found_d;
      out_err_q   <= res_err;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.match_now = out_match_q;
  assign result_o.found     = out_found_q;
  assign result_o.error     = out_err_q;

endmodule

>>> rtl/aws_checker.sv
// Port-level checker for the anagram window search block, bound to the top.
// Depends on aws_pkg and anagram_window_search_assert.svh.
`include "anagram_window_search_assert.svh"

module aws_checker import aws_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [KIND_W-1:0]   in_kind_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                out_match_i,
  input logic                out_found_i,
  input logic [ERR_W-1:0]    out_error_i
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result stays offered with the same contents.
  `AWS_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_stall,
    out_valid_i && $stable(out_match_i) && $stable(out_found_i) && $stable(out_error_i))

  // A matching window always raises the sticky flag.
  `AWS_ASSERT_NOW(a_match_sets_found, clk_i, rst_ni, out_valid_i && out_match_i,
    out_found_i)

  // A clear transaction yields an all-zero result in the next cycle.
  `AWS_ASSERT_NEXT(a_clear_result, clk_i, rst_ni, in_fire && (in_kind_i == KIND_CLEAR),
    out_valid_i && !out_match_i && !out_found_i && (out_error_i == ERR_NONE))

  // Only text transactions can report a match.
  `AWS_ASSERT_NEXT(a_match_only_text, clk_i, rst_ni, in_fire && (in_kind_i != KIND_TEXT),
    out_valid_i && !out_match_i)

endmodule

bind anagram_window_search aws_checker u_aws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .in_kind_i   (item_i.kind),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_match_i (result_o.match_now),
  .out_found_i (result_o.found),
  .out_error_i (result_o.error)
);
